@@ hw/rtl/mi4_pkg.sv @@
// Shared constants for the 4x4 matrix inverse unit.
package mi4_pkg;
  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int IDX_W = 4;
  localparam int OUT_W = 32;
  localparam int ONE_Q88 = 256;
  localparam int ONE_Q1616 = 65536;
  localparam int FRAC_SHIFT = 24;
endpackage

@@ hw/rtl/mi4_if.sv @@
// Valid/ready channel interfaces for the matrix inverse unit.
interface mi4_in_if #(parameter int EW = 16) (input logic clk);
  logic                 valid;
  logic                 ready;
  logic [3:0]           element_index;
  logic signed [EW-1:0] element_value;
  logic                 last;
  modport source (output valid, element_index, element_value, last, input ready);
  modport sink   (input valid, element_index, element_value, last, output ready);
endinterface

interface mi4_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               singular;
  logic               last_out;
  modport source (output valid, out_index, out_value, singular, last_out, input ready);
  modport sink   (input valid, out_index, out_value, singular, last_out, output ready);
endinterface

@@ hw/rtl/mi4_div.sv @@
// Restoring divider, one quotient bit per cycle, magnitudes only.
module mi4_div #(
  parameter int NW = 96,
  parameter int DW = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   sh;
  logic          ge;

  assign sh   = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign busy = (cnt_r != '0);
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= ge ? sh - {1'b0, den_r} : sh;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end
endmodule

@@ hw/rtl/mi4_core.sv @@
// Sequencer with one shared multiplier that builds cofactors and determinant; a divider forms the quotients.
module mi4_core #(
  parameter int EW = mi4_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mi4_in_if.sink   in_ch,
  mi4_out_if.source out_ch
);
  import mi4_pkg::*;
  // Term widths: triple product 3*EW, cofactor sum 3*EW+3, det 4*EW+5.
  localparam int AW = 3 * EW + 3;
  localparam int DTW = 4 * EW + 5;
  localparam int NW = AW + FRAC_SHIFT;
  localparam int MW = DTW;

  typedef enum logic [2:0] {S_LOAD, S_ADJ, S_DET, S_DIV, S_WAIT, S_OUT} state_t;

  state_t state_r;
  logic signed [EW-1:0] mat_r [16];
  logic signed [AW-1:0] adj_r [16];
  logic [3:0] k_r;      // adjugate / output index
  logic [2:0] t_r;      // term in cofactor
  logic [1:0] f_r;      // factor step
  logic signed [MW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [DTW-1:0] det_r;
  logic neg_r;
  logic sing_r;
  logic [31:0] val_r;

  // shared multiplier: wide operand times one element
  logic signed [MW-1:0] mul_a;
  logic signed [EW-1:0] mul_b;
  logic signed [MW+EW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // minor selection for adjugate (i=k>>2, j=k&3): rows skip j, cols skip i
  logic [1:0] ai, aj, r0, r1, r2, c0, c1, c2, ra, ca;
  logic [1:0] rr [3];
  logic [1:0] cc [3];
  logic [1:0] pc [3];
  assign ai = k_r[3:2];
  assign aj = k_r[1:0];
  assign r0 = (aj == 2'd0) ? 2'd1 : 2'd0;
  assign r1 = (aj <= 2'd1) ? 2'd2 : 2'd1;
  assign r2 = (aj <= 2'd2) ? 2'd3 : 2'd2;
  assign c0 = (ai == 2'd0) ? 2'd1 : 2'd0;
  assign c1 = (ai <= 2'd1) ? 2'd2 : 2'd1;
  assign c2 = (ai <= 2'd2) ? 2'd3 : 2'd2;
  assign rr[0] = r0;
  assign rr[1] = r1;
  assign rr[2] = r2;
  assign cc[0] = c0;
  assign cc[1] = c1;
  assign cc[2] = c2;

  always_comb begin
    case (t_r)
      3'd0: begin pc[0] = 2'd0; pc[1] = 2'd1; pc[2] = 2'd2; end
      3'd1: begin pc[0] = 2'd1; pc[1] = 2'd2; pc[2] = 2'd0; end
      3'd2: begin pc[0] = 2'd2; pc[1] = 2'd0; pc[2] = 2'd1; end
      3'd3: begin pc[0] = 2'd0; pc[1] = 2'd2; pc[2] = 2'd1; end
      3'd4: begin pc[0] = 2'd1; pc[1] = 2'd0; pc[2] = 2'd2; end
      default: begin pc[0] = 2'd2; pc[1] = 2'd1; pc[2] = 2'd0; end
    endcase
  end

  always_comb begin
    ra = rr[f_r];
    ca = cc[pc[f_r]];
    if (f_r == 2'd3) begin
      ra = 2'd0;
      ca = 2'd0;
    end
  end

  always_comb begin
    mul_a = prod_r;
    mul_b = mat_r[{ra, ca}];
    if (state_r == S_DET) begin
      mul_a = MW'(adj_r[{k_r[1:0], 2'b00}]);
      mul_b = mat_r[{2'b00, k_r[1:0]}];
    end
  end

  // divider on magnitudes
  logic signed [NW-1:0] num_s;
  logic [NW-1:0] num_m, quo;
  logic [DTW-1:0] den_m;
  logic div_start, div_busy;
  assign num_s = {adj_r[k_r], {FRAC_SHIFT{1'b0}}};
  assign num_m = num_s[NW-1] ? -num_s : num_s;
  assign den_m = det_r[DTW-1] ? -det_r : det_r;
  assign div_start = (state_r == S_DIV);

  mi4_div #(.NW(NW), .DW(DTW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_m), .den(den_m),
    .busy(div_busy), .quo(quo)
  );

  logic big;
  assign big = (quo[NW-1:31] != '0);

  assign in_ch.ready      = (state_r == S_LOAD);
  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.out_index = k_r;
  assign out_ch.out_value = val_r;
  assign out_ch.singular  = sing_r;
  assign out_ch.last_out  = (k_r == 4'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? EW'(ONE_Q88) : '0;
      end
      k_r <= '0;
      t_r <= '0;
      f_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_ch.valid) begin
            mat_r[in_ch.element_index] <= in_ch.element_value;
            if (in_ch.last) begin
              state_r <= S_ADJ;
              k_r <= '0;
              t_r <= '0;
              f_r <= '0;
              acc_r <= '0;
              prod_r <= MW'(1);
            end
          end
        end
        S_ADJ: begin
          // three multiply steps per term, then accumulate
          if (f_r != 2'd3) begin
            prod_r <= MW'(mul_p);
            f_r <= f_r + 2'd1;
          end else begin
            f_r <= '0;
            prod_r <= MW'(1);
            if (t_r == 3'd5) begin
              t_r <= '0;
              adj_r[k_r] <= ((ai[0] ^ aj[0]) ? -(acc_r - AW'(prod_r))
                                              : (acc_r - AW'(prod_r)));
              acc_r <= '0;
              k_r <= k_r + 4'd1;
              if (k_r == 4'd15) begin
                state_r <= S_DET;
                det_r <= '0;
              end
            end else begin
              t_r <= t_r + 3'd1;
              acc_r <= (t_r < 3'd3) ? acc_r + AW'(prod_r) : acc_r - AW'(prod_r);
            end
          end
        end
        S_DET: begin
          det_r <= det_r + DTW'(mul_p);
          if (k_r[1:0] == 2'd3) begin
            k_r <= '0;
            state_r <= S_DIV;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_DIV: begin
          sing_r <= (det_r == '0);
          neg_r <= num_s[NW-1] ^ det_r[DTW-1];
          state_r <= (det_r == '0) ? S_OUT : S_WAIT;
          // diagonal entries have equal row and column
          val_r <= (k_r[3:2] == k_r[1:0]) ? 32'(ONE_Q1616) : '0;
        end
        S_WAIT: begin
          if (!div_busy) begin
            state_r <= S_OUT;
            if (neg_r) begin
              val_r <= (big || quo[30:0] != '0 && quo[31]) ? 32'h8000_0000 :
                       -quo[31:0];
            end else begin
              val_r <= (big || quo[31]) ? 32'h7FFF_FFFF : quo[31:0];
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            k_r <= k_r + 4'd1;
            state_r <= (k_r == 4'd15) ? S_LOAD : S_DIV;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ hw/rtl/matrix_inverse_4x4_unit.sv @@
// Top level of the 4x4 matrix inverse unit.
// Usage:
//   in channel: one element per transfer (index, Q8.8 value, last).
//   A transfer without last only writes the stored matrix.
//   A transfer with last writes, then starts inversion; in_ready stays low
//   until all sixteen results have been taken.
//   Cofactors: 16 entries x 6 terms x 4 steps on one shared multiplier,
//   then the determinant is accumulated on the same multiplier.
//   Each result then passes a setup state, a bit-serial divide of
//   3*ELEMENT_WIDTH+27 quotient bits (75 at the default width), a state that
//   collects the quotient and one that presents it.
//   A singular matrix does not wait for the divider and emits identity with singular set.
//   out channel: results in row-major order, last_out on the sixteenth;
//   a stalled receiver holds the current result and the sequence.
//   Reset: matrix store returns to identity, the block is ready to load.
module matrix_inverse_4x4_unit #(
  parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  mi4_in_if.sink    in_ch,
  mi4_out_if.source out_ch
);
  import mi4_pkg::*;
  mi4_core #(.EW(ELEMENT_WIDTH)) u_core (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

@@ hw/rtl/mi4_checker.sv @@
// Port-level checks of the matrix inverse unit, bound to the top level.
module mi4_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] out_index,
  input logic out_last
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input ready while result pending");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == 4'd15)))
    else $error("last_out misplaced");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("result dropped while stalled");
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after run");
endmodule

bind matrix_inverse_4x4_unit mi4_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_index(out_ch.out_index), .out_last(out_ch.last_out)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the 4x4 matrix inverse unit.
module testbench;
  import mi4_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 460;
  localparam logic signed [191:0] Q_MAX = 192'sd2147483647;
  localparam logic signed [191:0] Q_MIN = -192'sd2147483648;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               singular;
    logic               last;
  } inv_result_t;

  logic clk;
  logic rst_n;

  mi4_in_if #(.EW(ELEMENT_WIDTH_DEF)) in_if (clk);
  mi4_out_if out_if (clk);

  matrix_inverse_4x4_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  logic signed [15:0] matrix_copy [16];
  inv_result_t        expected_inverse [$];
  int                 mismatches;
  int                 sent_items;
  int                 gap_pct;
  int                 stall_pct;
  int                 idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed 3x3 minor for adjugate entry (i, j): drop row j and column i.
  function automatic logic signed [191:0] cofactor(int i, int j);
    int rs [3];
    int cs [3];
    int n;
    logic signed [191:0] m [3][3];
    logic signed [191:0] acc;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != j) begin
      rs[n] = k;
      n = n + 1;
    end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != i) begin
      cs[n] = k;
      n = n + 1;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) m[a][b] = matrix_copy[rs[a] * 4 + cs[b]];
    acc = m[0][0] * m[1][1] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
        + m[0][2] * m[1][0] * m[2][1] - m[0][0] * m[1][2] * m[2][1]
        - m[0][1] * m[1][0] * m[2][2] - m[0][2] * m[1][1] * m[2][0];
    if (((i + j) % 2) != 0) acc = -acc;
    return acc;
  endfunction

  task automatic predict_inverse();
    logic signed [191:0] adj [16];
    logic signed [191:0] det;
    logic signed [191:0] q;
    inv_result_t r;
    det = 0;
    for (int k = 0; k < 16; k++) adj[k] = cofactor(k / 4, k % 4);
    for (int k = 0; k < 4; k++) det = det + adj[k * 4] * matrix_copy[k];
    for (int k = 0; k < 16; k++) begin
      r.idx = k[3:0];
      r.singular = (det == 0);
      r.last = (k == 15);
      if (det == 0) begin
        r.value = ((k % 5) == 0) ? ONE_Q1616 : 0;
      end else begin
        q = (adj[k] <<< FRAC_SHIFT) / det;
        if (q > Q_MAX) r.value = 32'sh7fffffff;
        else if (q < Q_MIN) r.value = 32'sh80000000;
        else r.value = q[31:0];
      end
      expected_inverse.push_back(r);
    end
  endtask

  task automatic send_element(logic [3:0] idx, logic [15:0] val, logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.element_index <= idx;
    in_if.element_value <= val;
    in_if.last <= last;
    do @(posedge clk); while (!in_if.ready);
    sent_items++;
    matrix_copy[idx] = val;
    if (last) predict_inverse();
  endtask

  // Hold the input until every pending result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_inverse.size() != 0) @(posedge clk);
  endtask

  task automatic send_matrix(logic [15:0] vals [16]);
    for (int k = 0; k < 16; k++) send_element(k[3:0], vals[k], k == 15);
  endtask

  function automatic logic [15:0] rand_element();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(7) - 3);
      3: return 16'($urandom_range(1023) - 512);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_directed();
    send_element(4'd0, 16'd256, 1'b1);   // identity store
    send_element(4'd5, 16'd0, 1'b1);     // zero row, singular
    send_element(4'd5, 16'd1, 1'b1);     // tiny pivot
    send_element(4'd10, 16'hffff, 1'b1); // negative diagonal entry
    send_element(4'd0, 16'h7fff, 1'b0);
    send_element(4'd5, 16'h8000, 1'b0);
    send_element(4'd10, 16'h7fff, 1'b0);
    send_element(4'd15, 16'h8000, 1'b1);
    send_element(4'd1, 16'h7fff, 1'b0);
    send_element(4'd4, 16'h8000, 1'b1);
    send_element(4'd2, 16'h0123, 1'b0);
    send_element(4'd8, 16'hfedc, 1'b1);
    send_element(4'd3, 16'h8000, 1'b0);
    send_element(4'd12, 16'h7fff, 1'b0);
    send_element(4'd15, 16'h7fff, 1'b1);
    drain_results();
  endtask

  task automatic test_random(int target);
    logic [15:0] vals [16];
    int kind;
    int n;
    while (sent_items < target) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        for (int k = 0; k < 16; k++) vals[k] = rand_element();
        // Force a zero determinant now and then.
        if ($urandom_range(4) == 0)
          for (int c = 0; c < 4; c++) vals[8 + c] = vals[c];
        else if ($urandom_range(9) == 0)
          for (int r = 0; r < 4; r++) vals[r * 4 + 1] = 16'd0;
        send_matrix(vals);
      end else if (kind < 85) begin
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++)
          send_element(4'($urandom_range(15)), rand_element(), k == n - 1);
      end else begin
        send_element(4'($urandom_range(15)), 16'($urandom_range(65535)), 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    inv_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_inverse.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result idx=%0d value=%0d",
                   out_if.out_index, out_if.out_value);
      end else begin
        e = expected_inverse.pop_front();
        if (out_if.out_index !== e.idx || out_if.out_value !== e.value ||
            out_if.singular !== e.singular || out_if.last_out !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch exp idx=%0d val=%0d sing=%0b last=%0b",
                      " got idx=%0d val=%0d sing=%0b last=%0b"},
                     e.idx, e.value, e.singular, e.last, out_if.out_index,
                     out_if.out_value, out_if.singular, out_if.last_out);
        end
      end
    end
  end

  // Count cycles without any transfer and stop with a mismatch at the watchdog limit.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches = 0;
    sent_items = 0;
    idle_cycles = 0;
    gap_pct = 15;
    stall_pct = 48;
    for (int k = 0; k < 16; k++) matrix_copy[k] = ((k % 5) == 0) ? 16'(ONE_Q88) : 16'sd0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.element_index <= '0;
    in_if.element_value <= '0;
    in_if.last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(RANDOM_ITEMS / 3);
    drain_results();
    gap_pct = 48;
    stall_pct = 15;
    test_random(2 * RANDOM_ITEMS / 3);
    drain_results();
    gap_pct = 0;
    stall_pct = 0;
    test_random(RANDOM_ITEMS);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_inverse.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/mi4_pkg.sv
hw/rtl/mi4_if.sv
hw/rtl/mi4_div.sv
hw/rtl/mi4_core.sv
hw/rtl/matrix_inverse_4x4_unit.sv
hw/rtl/mi4_checker.sv
tb/sv/testbench.sv
